@@ rtl/memory_write_filter_lru_buffer_unit_assert.svh @@
// Assertion macros for the memory write filter / LRU buffer block.
// Used by the port checker; needs clk and rst in scope.
`ifndef MEMORY_WRITE_FILTER_LRU_BUFFER_UNIT_ASSERT_SVH
`define MEMORY_WRITE_FILTER_LRU_BUFFER_UNIT_ASSERT_SVH
// same-cycle implication
`define MWF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mwf check failed");
// next-cycle implication
`define MWF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mwf check failed");
`endif

@@ rtl/mwflru_pkg.sv @@
// Shared constants for the memory write filter / LRU buffer block.
// No dependencies.
package mwflru_pkg;
  localparam int BufDepth    = 16;
  localparam int FilterWords = 4096;
  localparam int AddrW       = 48;
  localparam int LatW        = 16;
  localparam int CfgW        = 32;
  localparam int CfgIdxW     = 3;

  localparam logic [1:0] KIND_GETS  = 2'd0;
  localparam logic [1:0] KIND_GETX  = 2'd1;
  localparam logic [1:0] KIND_CLEAN = 2'd2;
  localparam logic [1:0] KIND_DIRTY = 2'd3;

  localparam logic [1:0] ST_INVALID   = 2'd0;
  localparam logic [1:0] ST_SHARED    = 2'd1;
  localparam logic [1:0] ST_EXCLUSIVE = 2'd2;
  localparam logic [1:0] ST_MODIFIED  = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_READ_LAT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WRITE_LAT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BUF_LAT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BUF_ENT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FLUSH     = 3'd4;

  localparam logic [LatW-1:0] READ_LAT_RST  = 16'd100;
  localparam logic [LatW-1:0] WRITE_LAT_RST = 16'd100;
  localparam logic [LatW-1:0] BUF_LAT_RST   = 16'd10;
endpackage

@@ rtl/mwflru_if.sv @@
// Request and response channel interfaces (valid/ready).
// Uses mwflru_pkg for widths.
interface mwflru_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [mwflru_pkg::AddrW-1:0]  line_addr;
  logic [mwflru_pkg::AddrW-1:0]  req_cycle;
  logic                          no_exclusive;
  modport source (output valid, kind, line_addr, req_cycle, no_exclusive, input ready);
  modport sink   (input valid, kind, line_addr, req_cycle, no_exclusive, output ready);
endinterface

interface mwflru_resp_if;
  logic                          valid;
  logic                          ready;
  logic [mwflru_pkg::AddrW-1:0]  resp_cycle;
  logic [1:0]                    granted_state;
  logic                          absorbed;
  logic                          mem_write;
  logic [mwflru_pkg::AddrW-1:0]  mem_write_addr;
  modport source (output valid, resp_cycle, granted_state, absorbed, mem_write,
                  mem_write_addr, input ready);
  modport sink   (input valid, resp_cycle, granted_state, absorbed, mem_write,
                  mem_write_addr, output ready);
endinterface

@@ rtl/memory_write_filter_lru_buffer_unit.sv @@
// Top level of the memory write filter with LRU write buffer.
// Depends on mwflru_pkg and the channel interfaces in mwflru_if.sv.
//
// Usage: requests arrive on req (valid/ready), one result per request leaves on
// resp. Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// One request is handled at a time. Get-shared, get-exclusive and clean
// writebacks pass through the dispatch and output states before the result
// is loaded. A dirty writeback reads the filter memory (registered read) when
// the filter is on, and goes straight to output with neither filter nor buffer
// in use; the buffer path scans the buffer memory one entry per cycle over the
// n entries in use. req.ready returns the cycle after a result is loaded.
// When a request passes the flush period the filter memory is cleared by a
// pass over all FILTER_WORDS words before the request continues.
// After reset the same clearing pass runs; req.ready stays low until it
// ends. A finished result sits in the output register; the next request is
// accepted while it waits, but its result holds until the receiver takes
// the earlier transaction.
// FILTER_WORDS must be a power of two.
module memory_write_filter_lru_buffer_unit #(
  parameter int BUF_DEPTH    = mwflru_pkg::BufDepth,
  parameter int FILTER_WORDS = mwflru_pkg::FilterWords
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mwflru_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mwflru_pkg::CfgW-1:0]    cfg_data,
  mwflru_req_if.sink                     req,
  mwflru_resp_if.source                  resp
);
  localparam int AW = mwflru_pkg::AddrW;
  localparam int LW = mwflru_pkg::LatW;
  localparam int WW = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
  localparam int IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CW = $clog2(BUF_DEPTH + 1);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_FCHK  = 3'd3;
  localparam logic [2:0] S_BSCAN = 3'd4;
  localparam logic [2:0] S_BRES  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]    state;
  logic [LW-1:0] read_latency, write_latency, buffer_latency;
  logic [4:0]    buffer_entries;
  logic [31:0]   flush_period;
  logic [AW-1:0] last_flush;
  logic [WW-1:0] clr_cnt;
  logic          clr_pend;
  logic [CW-1:0] buf_fill;

  // transaction being processed
  logic [1:0]    k_kind;
  logic [AW-1:0] k_addr, k_cyc;
  logic          k_noex;
  // result under construction
  logic [1:0]    r_state;
  logic          r_abs, r_mw;
  logic [AW-1:0] r_mwaddr;
  logic [LW-1:0] r_lat;
  // buffer scan
  logic [CW-1:0] rd_idx, cmp_idx;
  logic          cmp_vld, hit, have_min;
  logic [CW-1:0] hit_idx, vic_idx;
  logic [AW-1:0] min_stamp, vic_line;
  // output register
  logic          out_valid, out_load;
  logic [AW-1:0] o_resp, o_mwaddr;
  logic [1:0]    o_state;
  logic          o_abs, o_mw;

  // memories
  logic [63:0]   filt_mem [FILTER_WORDS];
  logic [63:0]   filt_q;
  logic          filt_we;
  logic [WW-1:0] filt_waddr, word_idx;
  logic [63:0]   filt_wdata, bit_mask;
  logic [AW-1:0] line_mem  [BUF_DEPTH];
  logic [AW-1:0] stamp_mem [BUF_DEPTH];
  logic [AW-1:0] line_q, stamp_q;
  logic          line_we, stamp_we;
  logic [IW-1:0] buf_waddr;

  logic [CW-1:0] n_use, lim;
  logic          accept, flush_hit, bit_set;
  logic [AW-1:0] elapsed;
  logic [AW:0]   sum;

  assign word_idx = k_addr[WW+5:6];
  assign bit_mask = 64'd1 << k_addr[5:0];
  assign bit_set  = (filt_q & bit_mask) != 64'd0;
  assign n_use    = (int'(buffer_entries) > BUF_DEPTH) ? CW'(BUF_DEPTH)
                                                       : CW'(buffer_entries);
  assign lim      = (buf_fill < n_use) ? buf_fill : n_use;
  assign accept   = req.valid && req.ready;
  assign elapsed  = req.req_cycle - last_flush;
  assign flush_hit = (flush_period != 32'd0) && (elapsed >= {16'd0, flush_period});
  assign sum      = {1'b0, k_cyc} + {{(AW + 1 - LW){1'b0}}, r_lat};
  assign req.ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || resp.ready);

  assign resp.valid          = out_valid;
  assign resp.resp_cycle     = o_resp;
  assign resp.granted_state  = o_state;
  assign resp.absorbed       = o_abs;
  assign resp.mem_write      = o_mw;
  assign resp.mem_write_addr = o_mwaddr;

  always_comb begin
    filt_we    = 1'b0;
    filt_waddr = clr_cnt;
    filt_wdata = 64'd0;
    if (state == S_CLR) begin
      filt_we = 1'b1;
    end else if (state == S_FCHK && !bit_set) begin
      filt_we    = 1'b1;
      filt_waddr = word_idx;
      filt_wdata = filt_q | bit_mask;
    end
  end

  always_comb begin
    line_we   = 1'b0;
    stamp_we  = 1'b0;
    buf_waddr = vic_idx[IW-1:0];
    if (state == S_BRES) begin
      stamp_we = 1'b1;
      if (hit) begin
        buf_waddr = hit_idx[IW-1:0];
      end else begin
        line_we = 1'b1;
        if (buf_fill < n_use) buf_waddr = buf_fill[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (filt_we) filt_mem[filt_waddr] <= filt_wdata;
    filt_q <= filt_mem[word_idx];
  end

  always_ff @(posedge clk) begin
    if (line_we)  line_mem[buf_waddr]  <= k_addr;
    if (stamp_we) stamp_mem[buf_waddr] <= k_cyc;
    line_q  <= line_mem[rd_idx[IW-1:0]];
    stamp_q <= stamp_mem[rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_latency   <= mwflru_pkg::READ_LAT_RST;
      write_latency  <= mwflru_pkg::WRITE_LAT_RST;
      buffer_latency <= mwflru_pkg::BUF_LAT_RST;
      buffer_entries <= 5'd0;
      flush_period   <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mwflru_pkg::REG_READ_LAT:  read_latency   <= cfg_data[LW-1:0];
        mwflru_pkg::REG_WRITE_LAT: write_latency  <= cfg_data[LW-1:0];
        mwflru_pkg::REG_BUF_LAT:   buffer_latency <= cfg_data[LW-1:0];
        mwflru_pkg::REG_BUF_ENT:   buffer_entries <= cfg_data[4:0];
        mwflru_pkg::REG_FLUSH:     flush_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      clr_pend   <= 1'b0;
      last_flush <= '0;
      buf_fill   <= '0;
      out_valid  <= 1'b0;
      cmp_vld    <= 1'b0;
    end else begin
      if (resp.valid && resp.ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == WW'(FILTER_WORDS - 1)) begin
            clr_cnt <= '0;
            state   <= clr_pend ? S_DISP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            k_kind <= req.kind;
            k_addr <= req.line_addr;
            k_cyc  <= req.req_cycle;
            k_noex <= req.no_exclusive;
            if (flush_hit) begin
              last_flush <= req.req_cycle;
              clr_pend   <= 1'b1;
              state      <= S_CLR;
            end else begin
              state <= S_DISP;
            end
          end
        end
        S_DISP: begin
          clr_pend <= 1'b0;
          r_abs    <= 1'b0;
          r_mw     <= 1'b0;
          r_mwaddr <= '0;
          rd_idx   <= '0;
          cmp_vld  <= 1'b0;
          hit      <= 1'b0;
          have_min <= 1'b0;
          case (k_kind)
            mwflru_pkg::KIND_GETS: begin
              r_state <= k_noex ? mwflru_pkg::ST_SHARED : mwflru_pkg::ST_EXCLUSIVE;
              r_lat   <= read_latency;
              state   <= S_OUT;
            end
            mwflru_pkg::KIND_GETX: begin
              r_state <= mwflru_pkg::ST_MODIFIED;
              r_lat   <= read_latency;
              state   <= S_OUT;
            end
            mwflru_pkg::KIND_CLEAN: begin
              r_state <= mwflru_pkg::ST_INVALID;
              r_lat   <= '0;
              state   <= S_OUT;
            end
            default: begin
              r_state  <= mwflru_pkg::ST_INVALID;
              r_mw     <= 1'b1;
              r_mwaddr <= k_addr;
              r_lat    <= write_latency;
              if (flush_period != 32'd0) state <= S_FCHK;
              else if (n_use != '0)      state <= S_BSCAN;
              else                       state <= S_OUT;
            end
          endcase
        end
        S_FCHK: begin
          // first dirty writeback to a filter bit in the period, or any with no buffer entries, goes to memory
          if (!bit_set || n_use == '0) state <= S_OUT;
          else                         state <= S_BSCAN;
        end
        S_BSCAN: begin
          if (rd_idx < n_use) rd_idx <= rd_idx + 1'b1;
          cmp_vld <= (rd_idx < n_use);
          cmp_idx <= rd_idx;
          if (cmp_vld) begin
            if (!hit && cmp_idx < lim && line_q == k_addr) begin
              hit     <= 1'b1;
              hit_idx <= cmp_idx;
            end
            if (!have_min || min_stamp > stamp_q) begin
              have_min  <= 1'b1;
              min_stamp <= stamp_q;
              vic_idx   <= cmp_idx;
              vic_line  <= line_q;
            end
          end
          if (rd_idx == n_use && !cmp_vld) state <= S_BRES;
        end
        S_BRES: begin
          if (hit || buf_fill < n_use) begin
            r_abs    <= 1'b1;
            r_mw     <= 1'b0;
            r_mwaddr <= '0;
            r_lat    <= buffer_latency;
            if (!hit) buf_fill <= buf_fill + 1'b1;
          end else begin
            r_mwaddr <= vic_line;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            o_resp    <= sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
            o_state   <= r_state;
            o_abs     <= r_abs;
            o_mw      <= r_mw;
            o_mwaddr  <= r_mwaddr;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/mwflru_checker.sv @@
// Port-level checker for the memory write filter / LRU buffer block, and its bind.
// Uses the assertion macros header.
`include "memory_write_filter_lru_buffer_unit_assert.svh"
module mwflru_checker (
  input logic        clk,
  input logic        rst,
  input logic        resp_valid,
  input logic        resp_ready,
  input logic [47:0] resp_cycle,
  input logic [1:0]  granted_state,
  input logic        absorbed,
  input logic        mem_write,
  input logic [47:0] mem_write_addr
);
  `MWF_ASSERT_NEXT(a_hold, resp_valid && !resp_ready, resp_valid && $stable(resp_cycle))
  `MWF_ASSERT_NOW(a_abs_nowr, resp_valid && absorbed, !mem_write)
  `MWF_ASSERT_NOW(a_addr_zero, resp_valid && !mem_write, mem_write_addr == 48'd0)
  `MWF_ASSERT_NOW(a_abs_inv, resp_valid && absorbed, granted_state == mwflru_pkg::ST_INVALID)
endmodule

bind memory_write_filter_lru_buffer_unit mwflru_checker u_mwflru_checker (
  .clk(clk), .rst(rst),
  .resp_valid(resp.valid), .resp_ready(resp.ready),
  .resp_cycle(resp.resp_cycle), .granted_state(resp.granted_state),
  .absorbed(resp.absorbed), .mem_write(resp.mem_write),
  .mem_write_addr(resp.mem_write_addr)
);
